// File: rtl/core/gog_pkg.sv
`timescale 1ns / 1ps
// gog_pkg: shared constants and helpers for the gather offset generator
// no dependencies

package gog_pkg;

  // geometry
  localparam int unsigned MaxDims      = 4;
  localparam int unsigned DimW         = 16;
  localparam int unsigned IdxW         = 32;
  localparam int unsigned OfsW         = 32;
  localparam int unsigned CfgW         = 64;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned DimCntW      = 3;
  localparam int unsigned DimSelW      = 2;

  // divider layout: a few quotient bits per register stage
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned StagesPerDim = IdxW / BitsPerStage;
  localparam int unsigned DivStages    = StagesPerDim * MaxDims;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegDimCount     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSkippedDim   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDimSizes     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIndexStrides = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFirstStrides = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSecondStrides = 3'd5;

  localparam logic [CfgW-1:0] DimSizesReset = 64'h0001_0001_0001_0001;

  // pick 16-bit field d of a packed register
  function automatic logic [DimW-1:0] field16(input logic [CfgW-1:0] packed_v,
                                              input logic [DimSelW-1:0] d);
    logic [DimW-1:0] res;
    res = '0;
    case (d)
      2'd0:    res = packed_v[15:0];
      2'd1:    res = packed_v[31:16];
      2'd2:    res = packed_v[47:32];
      2'd3:    res = packed_v[63:48];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/gather_offset_generator.sv
`timescale 1ns / 1ps
// gather_offset_generator: linear index to three strided tensor offsets
// depends on gog_pkg

// Takes one 32-bit linear index per cycle when not stalled and returns the
// element offsets into the index tensor, the first tensor and the second
// tensor (skipped dimension left out of the second). 32 divider stages,
// four quotient bits each, peel the coordinates from the last dimension in
// use down to dimension 0, then one stage multiplies coordinates by strides
// and one stage sums and holds the result. Throughput is one transaction per
// cycle; the whole pipeline advances when the output register is empty or taken.
// Size fields of zero act as one; dim_count above four acts as four. Write
// configuration only while no transaction is in flight.

module gather_offset_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [gog_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gog_pkg::CfgW-1:0]     cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gog_pkg::IdxW-1:0]     linear_index_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gog_pkg::OfsW-1:0]     index_offset_o,
  output logic [gog_pkg::OfsW-1:0]     first_offset_o,
  output logic [gog_pkg::OfsW-1:0]     second_offset_o
);

  localparam int unsigned NS  = gog_pkg::DivStages;
  localparam int unsigned ND  = gog_pkg::MaxDims;
  localparam int unsigned DW  = gog_pkg::DimW;
  localparam int unsigned IW  = gog_pkg::IdxW;
  localparam int unsigned OW  = gog_pkg::OfsW;

  // configuration registers
  logic [gog_pkg::DimCntW-1:0] dim_count_q;
  logic [gog_pkg::DimSelW-1:0] skipped_dim_q;
  logic [gog_pkg::CfgW-1:0]    dim_sizes_q;
  logic [gog_pkg::CfgW-1:0]    index_strides_q;
  logic [gog_pkg::CfgW-1:0]    first_strides_q;
  logic [gog_pkg::CfgW-1:0]    second_strides_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q      <= 3'd1;
      skipped_dim_q    <= '0;
      dim_sizes_q      <= gog_pkg::DimSizesReset;
      index_strides_q  <= '0;
      first_strides_q  <= '0;
      second_strides_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gog_pkg::RegDimCount:      dim_count_q      <= cfg_wdata_i[gog_pkg::DimCntW-1:0];
        gog_pkg::RegSkippedDim:    skipped_dim_q    <= cfg_wdata_i[gog_pkg::DimSelW-1:0];
        gog_pkg::RegDimSizes:      dim_sizes_q      <= cfg_wdata_i;
        gog_pkg::RegIndexStrides:  index_strides_q  <= cfg_wdata_i;
        gog_pkg::RegFirstStrides:  first_strides_q  <= cfg_wdata_i;
        gog_pkg::RegSecondStrides: second_strides_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-step divisor and strides; step j handles dimension n-1-j
  logic [gog_pkg::DimCntW-1:0] n_dims;
  logic [DW-1:0] step_size   [ND];
  logic [DW-1:0] step_istr   [ND];
  logic [DW-1:0] step_fstr   [ND];
  logic [DW-1:0] step_sstr   [ND];

  always_comb begin
    logic [gog_pkg::DimCntW-1:0] dsel;
    logic [DW-1:0]               sz;
    n_dims = (dim_count_q > gog_pkg::DimCntW'(ND)) ? gog_pkg::DimCntW'(ND) : dim_count_q;
    for (int j = 0; j < ND; j++) begin
      dsel = n_dims - gog_pkg::DimCntW'(j + 1);
      sz   = gog_pkg::field16(dim_sizes_q, dsel[gog_pkg::DimSelW-1:0]);
      if (gog_pkg::DimCntW'(j) < n_dims) begin
        step_size[j] = (sz == '0) ? DW'(1) : sz;
        step_istr[j] = gog_pkg::field16(index_strides_q, dsel[gog_pkg::DimSelW-1:0]);
        step_fstr[j] = gog_pkg::field16(first_strides_q, dsel[gog_pkg::DimSelW-1:0]);
        step_sstr[j] = (dsel[gog_pkg::DimSelW-1:0] == skipped_dim_q) ? '0 :
                       gog_pkg::field16(second_strides_q, dsel[gog_pkg::DimSelW-1:0]);
      end else begin
        // unused step: divide by one, coordinate is zero
        step_size[j] = DW'(1);
        step_istr[j] = '0;
        step_fstr[j] = '0;
        step_sstr[j] = '0;
      end
    end
  end

  // pipeline advance
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // divider pipeline: remainder, dividend/quotient shift word, coordinates
  logic          v_q   [NS];
  logic [DW:0]   r_q   [NS];
  logic [IW-1:0] nq_q  [NS];
  logic [DW-1:0] crd_q [NS][ND];

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int unsigned J   = s / gog_pkg::StagesPerDim;
    localparam int unsigned SUB = s % gog_pkg::StagesPerDim;
    // previous stage and previous step, clamped so stage 0 stays in range
    localparam int unsigned P   = (s == 0) ? 0 : s - 1;
    localparam int unsigned JP  = (J == 0) ? 0 : J - 1;

    logic          v_d;
    logic [DW:0]   r_d;
    logic [IW-1:0] nq_d;
    logic [DW-1:0] crd_d [ND];

    // load stage inputs, close the previous step at a step boundary
    always_comb begin
      logic [DW:0]   r_w;
      logic [IW-1:0] nq_w;
      logic [DW:0]   r2;
      logic          ge;
      if (s == 0) begin
        v_d  = in_valid_i;
        r_w  = '0;
        nq_w = linear_index_i;
        for (int k = 0; k < ND; k++) crd_d[k] = '0;
      end else begin
        v_d  = v_q[P];
        r_w  = r_q[P];
        nq_w = nq_q[P];
        for (int k = 0; k < ND; k++) crd_d[k] = crd_q[P][k];
        if (SUB == 0) begin
          crd_d[JP] = r_q[P][DW-1:0];
          r_w       = '0;
        end
      end
      // restoring division, a few bits
      for (int b = 0; b < gog_pkg::BitsPerStage; b++) begin
        r2   = {r_w[DW-1:0], nq_w[IW-1]};
        ge   = (r2 >= {1'b0, step_size[J]});
        r_w  = ge ? (r2 - {1'b0, step_size[J]}) : r2;
        nq_w = {nq_w[IW-2:0], ge};
      end
      r_d  = r_w;
      nq_d = nq_w;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv) begin
        v_q[s] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[s]  <= r_d;
        nq_q[s] <= nq_d;
        for (int k = 0; k < ND; k++) crd_q[s][k] <= crd_d[k];
      end
    end
  end

  // coordinate times stride
  logic          pv_q;
  logic [OW-1:0] pi_q [ND];
  logic [OW-1:0] pf_q [ND];
  logic [OW-1:0] ps_q [ND];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW-1:0] c;
    if (adv) begin
      for (int j = 0; j < ND; j++) begin
        c       = (j == ND - 1) ? r_q[NS-1][DW-1:0] : crd_q[NS-1][j];
        pi_q[j] <= OW'(c) * OW'(step_istr[j]);
        pf_q[j] <= OW'(c) * OW'(step_fstr[j]);
        ps_q[j] <= OW'(c) * OW'(step_sstr[j]);
      end
    end
  end

  // sum into the output register
  logic [OW-1:0] index_ofs_q;
  logic [OW-1:0] first_ofs_q;
  logic [OW-1:0] second_ofs_q;
  logic [OW-1:0] si_d;
  logic [OW-1:0] sf_d;
  logic [OW-1:0] ss_d;

  always_comb begin
    si_d = '0;
    sf_d = '0;
    ss_d = '0;
    for (int j = 0; j < ND; j++) begin
      si_d = si_d + pi_q[j];
      sf_d = sf_d + pf_q[j];
      ss_d = ss_d + ps_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      index_ofs_q  <= si_d;
      first_ofs_q  <= sf_d;
      second_ofs_q <= ss_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign index_offset_o  = index_ofs_q;
  assign first_offset_o  = first_ofs_q;
  assign second_offset_o = second_ofs_q;

endmodule
